FILE: design/euclidean_distance_bytes_unit_macros.svh
// Assertion macros shared by the euclidean distance unit
`ifndef EUCLIDEAN_DISTANCE_BYTES_UNIT_MACROS_SVH
`define EUCLIDEAN_DISTANCE_BYTES_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define EDB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define EDB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/edb_pkg.sv
// Package: widths, limits and shared types of the euclidean distance unit
`default_nettype none
package edb_pkg;

    localparam int BYTE_W       = 8;
    localparam int SQ_W         = 2 * BYTE_W;
    localparam int SUM_W        = 28;
    localparam int FRAC_BITS    = 8;
    localparam int DIST_W       = 22;
    localparam int MAX_FEATURES = 4096;
    localparam int CNT_W        = $clog2(MAX_FEATURES + 1);
    localparam int OPND_W       = SUM_W + 2 * FRAC_BITS;
    localparam int SQRT_STEPS   = OPND_W / 2;
    localparam int STEP_W       = $clog2(SQRT_STEPS);
    localparam int REM_W        = DIST_W + 3;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             ovf;
    } edb_acc_t;

    typedef struct packed {
        logic busy;
    } edb_sqrt_stat_t;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_ROOT,
        ST_HOLD
    } edb_state_t;

endpackage
`default_nettype wire

FILE: design/edb_accum.sv
// Row accumulator: squared byte difference added into a saturating sum
`default_nettype none
module edb_accum (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      take,
    input  wire logic [edb_pkg::BYTE_W-1:0] sample_byte,
    input  wire logic [edb_pkg::BYTE_W-1:0] query_byte,
    input  wire logic                      last_feature,
    output edb_pkg::edb_acc_t              acc
);
    import edb_pkg::*;

    logic [SUM_W-1:0]  sum_reg,   sum_next;
    logic              ovf_reg,   ovf_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic [BYTE_W-1:0] diff;
    logic [SQ_W-1:0]   sq;
    logic [SUM_W:0]    sum_add;
    edb_acc_t          upd;
    logic [CNT_W-1:0]  count_upd;

    always_comb
    begin
        diff    = (sample_byte >= query_byte) ? (sample_byte - query_byte)
                                              : (query_byte - sample_byte);
        sq      = SQ_W'(diff) * SQ_W'(diff);
        sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(sq);
        upd.sum   = sum_reg;
        upd.ovf   = ovf_reg;
        count_upd = count_reg;
        if (count_reg >= CNT_W'(MAX_FEATURES))
        begin
            upd.sum = SUM_MAX;
            upd.ovf = 1'b1;
        end
        else
        begin
            count_upd = count_reg + CNT_W'(1);
            if (sum_add[SUM_W])
            begin
                upd.sum = SUM_MAX;
                upd.ovf = 1'b1;
            end
            else
            begin
                upd.sum = sum_add[SUM_W-1:0];
            end
        end
    end

    always_comb
    begin
        sum_next   = sum_reg;
        ovf_next   = ovf_reg;
        count_next = count_reg;
        if (take)
        begin
            if (last_feature)
            begin
                sum_next   = '0;
                ovf_next   = 1'b0;
                count_next = '0;
            end
            else
            begin
                sum_next   = upd.sum;
                ovf_next   = upd.ovf;
                count_next = count_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            ovf_reg   <= ovf_next;
            count_reg <= count_next;
        end
    end

    assign acc = upd;

endmodule
`default_nettype wire

FILE: design/edb_sqrt.sv
// Shared square root unit: one result bit per cycle, digit recurrence
`default_nettype none
module edb_sqrt (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [edb_pkg::SUM_W-1:0] operand,
    output edb_pkg::edb_sqrt_stat_t        stat,
    output logic [edb_pkg::DIST_W-1:0]     root
);
    import edb_pkg::*;

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [REM_W-1:0]  rem_reg,  rem_next;
    logic [DIST_W-1:0] root_reg, root_next;
    logic [OPND_W-1:0] opnd_reg, opnd_next;

    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;

    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], opnd_reg[OPND_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        opnd_next = opnd_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(SQRT_STEPS - 1);
            rem_next  = '0;
            root_next = '0;
            opnd_next = {operand, {(2 * FRAC_BITS){1'b0}}};
        end
        else if (busy_reg)
        begin
            opnd_next = {opnd_reg[OPND_W-3:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_next  = rem_shift - trial;
                root_next = {root_reg[DIST_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift;
                root_next = {root_reg[DIST_W-2:0], 1'b0};
            end
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                step_next = step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        opnd_reg <= opnd_next;
    end

    assign stat.busy = busy_reg;
    assign root      = root_reg;

endmodule
`default_nettype wire

FILE: design/euclidean_distance_bytes_unit.sv
// Top level: euclidean distance of streamed byte rows with sequencer and result register
//
//   channel | ports                                          | transaction
//   --------+------------------------------------------------+-------------------------
//   in      | in_valid, in_stall, sample_byte, query_byte,   | one feature byte pair
//           | last_feature                                   |
//   out     | out_valid, out_stall, sum_squares,             | one result per row
//           | distance_fixed, overflowed                     |
//
// A feature that does not end a row is added into the row sum; rows stream at one
// feature per cycle while in_stall is low. The last feature of a row starts the shared
// square root unit, which resolves one result bit per cycle: in_stall stays high while
// it runs its 22 root steps and while the result register is loaded. Further stall
// cycles follow only while a previous result waits in the result register at root end.
// A result waiting in the result register does not block features of the next row.
// Reset clears the row sum, overflow flag, feature count and all valid state at once.
`default_nettype none
`include "euclidean_distance_bytes_unit_macros.svh"
module euclidean_distance_bytes_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [edb_pkg::BYTE_W-1:0] sample_byte,
    input  wire logic [edb_pkg::BYTE_W-1:0] query_byte,
    input  wire logic                       last_feature,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [edb_pkg::SUM_W-1:0]       sum_squares,
    output logic [edb_pkg::DIST_W-1:0]      distance_fixed,
    output logic                            overflowed
);
    import edb_pkg::*;

    edb_state_t        state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]  sum_out_reg;
    logic [DIST_W-1:0] dist_out_reg;
    logic              ovf_out_reg;
    logic [SUM_W-1:0]  sum_hold_reg;
    logic              ovf_hold_reg;

    logic              in_accept;
    logic              row_end;
    logic              slot_free;
    logic              load_out;
    edb_acc_t          acc;
    edb_sqrt_stat_t    sqrt_stat;
    logic [DIST_W-1:0] sqrt_root;

    assign in_accept = in_valid && !in_stall;
    assign row_end   = in_accept && last_feature;
    assign slot_free = !out_valid_reg || !out_stall;

    edb_accum u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (in_accept),
        .sample_byte  (sample_byte),
        .query_byte   (query_byte),
        .last_feature (last_feature),
        .acc          (acc)
    );

    edb_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (row_end),
        .operand (acc.sum),
        .stat    (sqrt_stat),
        .root    (sqrt_root)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCUM:
            begin
                if (row_end)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (!sqrt_stat.busy)
                begin
                    state_next = slot_free ? ST_ACCUM : ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    state_next = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        load_out = 1'b0;
        case (state_reg)
            ST_ACCUM:
            begin
                in_stall = 1'b0;
            end
            ST_ROOT:
            begin
                load_out = !sqrt_stat.busy && slot_free;
            end
            ST_HOLD:
            begin
                load_out = slot_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_end)
        begin
            sum_hold_reg <= acc.sum;
            ovf_hold_reg <= acc.ovf;
        end
        if (load_out)
        begin
            sum_out_reg  <= sum_hold_reg;
            dist_out_reg <= sqrt_root;
            ovf_out_reg  <= ovf_hold_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign sum_squares    = sum_out_reg;
    assign distance_fixed = dist_out_reg;
    assign overflowed     = ovf_out_reg;

    `EDB_ASSERT_NOW(a_stall_while_root, sqrt_stat.busy, in_stall,
        "input taken while square root unit busy")
    `EDB_ASSERT_NEXT(a_row_end_starts_root, row_end, sqrt_stat.busy && state_reg == ST_ROOT,
        "row end did not start square root unit")
    `EDB_ASSERT_NOW(a_ovf_means_max, out_valid && overflowed, sum_squares == SUM_MAX,
        "overflow flagged without saturated sum")
    `EDB_ASSERT_NOW(a_load_needs_idle_root, load_out, !sqrt_stat.busy,
        "result loaded before square root finished")

endmodule
`default_nettype wire
